// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of the tokenizer.
// Each macro expands to one labeled concurrent assertion that reports through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define DRT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define DRT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/drt_pkg.sv =====
// Types and constants of the delimited record tokenizer.
// Used by the controller, the datapath and the top level; depends on nothing.
package drt_pkg;

    localparam int FIELD_W     = 5;
    localparam int KIND_FIELDS = 24;
    localparam int KINDS_W     = 48;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_FIELD_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_KINDS = 1'b1;

    localparam logic [FIELD_W-1:0] FIELD_COUNT_RST = 5'd18;
    localparam logic [KINDS_W-1:0] FIELD_KINDS_RST = 48'h0008_0C62_8010;

    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_TRUE  = 8'h56;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [31:0] INT_MAG_MAX = 32'h8000_0000;
    localparam logic [31:0] INT_POS_MAX = 32'h7FFF_FFFF;

    typedef enum logic [2:0] {
        MODE_START,
        MODE_TEXT,
        MODE_LOPEN,
        MODE_LELEM,
        MODE_LSKIP
    } mode_t;

    typedef enum logic [1:0] {
        KIND_STRING,
        KIND_LIST,
        KIND_BOOL,
        KIND_INT
    } kind_t;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        CT_IDLE,
        CT_STEP,
        CT_FINISH
    } ctl_state_t;

    typedef struct packed {
        logic sel_held;
        logic step;
        logic publish;
        logic finish;
    } drt_cmd_t;

    typedef struct packed {
        logic out_valid;
        logic in_range;
        logic more;
        logic last;
        logic emit;
    } drt_sts_t;

    typedef struct packed {
        logic [FIELD_W-1:0] field_index;
        logic [7:0]         element_index;
        logic [7:0]         char_out;
        logic               is_content;
        logic               element_end;
        logic               field_end;
        logic [7:0]         element_count;
        logic               bool_value;
        logic signed [31:0] int_value;
        logic               line_done;
    } drt_rec_t;

endpackage

// ===== design/drt_ctrl.sv =====
// Controller of the tokenizer: sequences byte steps, repeated steps and line-end close.
// Depends on drt_pkg for the state, command and status types.
module drt_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                m_ready,
    input  drt_pkg::drt_sts_t   sts,
    output logic                s_ready,
    output drt_pkg::drt_cmd_t   cmd
);

    drt_pkg::ctl_state_t state_reg;
    drt_pkg::ctl_state_t state_next;
    drt_pkg::ctl_state_t after_step;
    logic                out_free;
    logic                pub_step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= drt_pkg::CT_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Where a step leads: more results for the held byte, a line-end close, or done.
    always_comb begin
        pub_step   = 1'b0;
        after_step = drt_pkg::CT_IDLE;
        priority if (sts.more) begin
            pub_step   = 1'b1;
            after_step = drt_pkg::CT_STEP;
        end else if (sts.last && sts.in_range) begin
            after_step = drt_pkg::CT_FINISH;
        end else begin
            pub_step = sts.emit;
        end
    end

    always_comb begin
        out_free   = !sts.out_valid || m_ready;
        cmd        = '0;
        s_ready    = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            drt_pkg::CT_IDLE: begin
                s_ready = out_free;
                if (s_valid && out_free) begin
                    cmd.step    = 1'b1;
                    cmd.publish = pub_step;
                    state_next  = after_step;
                end
            end
            drt_pkg::CT_STEP: begin
                cmd.sel_held = 1'b1;
                if (out_free) begin
                    cmd.step    = 1'b1;
                    cmd.publish = pub_step;
                    state_next  = after_step;
                end
            end
            drt_pkg::CT_FINISH: begin
                // output slot is empty here: the stepped record was not published
                cmd.finish = 1'b1;
                state_next = drt_pkg::CT_IDLE;
            end
            default: begin
                state_next = drt_pkg::CT_IDLE;
            end
        endcase
    end

endmodule

// ===== design/drt_datapath.sv =====
// Datapath of the tokenizer: config registers, parse state, held byte, one parse step per
// cycle unless the output is stalled, line-end close and the output register. Depends on drt_pkg.
module drt_datapath #(
    parameter int MAX_FIELDS   = 24,
    parameter int MAX_ELEMENTS = 255
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [7:0]                          s_data_byte,
    input  logic                                s_last_of_line,
    input  logic                                m_ready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [drt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [drt_pkg::KINDS_W-1:0]         cfg_data,
    input  drt_pkg::drt_cmd_t                   cmd,
    output drt_pkg::drt_sts_t                   sts,
    output logic                                m_valid,
    output drt_pkg::drt_rec_t                   rec
);

    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    logic [drt_pkg::FIELD_W-1:0] count_reg;
    logic [drt_pkg::KINDS_W-1:0] kinds_reg;

    logic [drt_pkg::FIELD_W-1:0] cur_reg,   cur_next;
    drt_pkg::mode_t              mode_reg,  mode_next;
    logic [CW-1:0]               cnt_reg,   cnt_next;
    logic                        first_reg, first_next;
    logic                        true_reg,  true_next;
    logic [31:0]                 acc_reg,   acc_next;
    logic                        neg_reg,   neg_next;
    drt_pkg::phase_t             phase_reg, phase_next;

    logic [7:0]                  byte_reg;
    logic                        last_reg;
    logic                        out_valid_reg, out_valid_next;
    drt_pkg::drt_rec_t           rec_reg, rec_next;

    logic [7:0]                  b;
    logic                        lst;
    logic [drt_pkg::FIELD_W:0]   lim;
    logic                        in_range;
    drt_pkg::kind_t              kind;
    logic                        is_start;
    logic                        cont;

    logic [CW-1:0]               e_cnt;
    logic                        e_first;
    logic                        e_true;
    logic [31:0]                 e_acc;
    logic                        e_neg;
    drt_pkg::phase_t             e_phase;

    logic                        is_blank;
    logic                        is_digit;
    logic [35:0]                 acc_prod;
    logic [31:0]                 acc_step;

    drt_pkg::drt_rec_t           it_rec;
    drt_pkg::drt_rec_t           fin_rec;
    logic [CW-1:0]               fin_cnt;

    function automatic logic [7:0] clamp8(logic [CW-1:0] c);
        logic [16:0] e;
        e = 17'(c);
        return (e > 17'd255) ? 8'hFF : e[7:0];
    endfunction

    function automatic logic [CW-1:0] bump(logic [CW-1:0] c);
        return (17'(c) < 17'(MAX_ELEMENTS)) ? CW'(c + 1'b1) : c;
    endfunction

    function automatic drt_pkg::drt_rec_t fill_end(
        drt_pkg::drt_rec_t r,
        drt_pkg::kind_t    k,
        logic [7:0]        cnt8,
        logic              first,
        logic              tru,
        logic [31:0]       acc,
        logic              neg
    );
        drt_pkg::drt_rec_t o;
        o = r;
        o.field_end = 1'b1;
        if (k == drt_pkg::KIND_LIST) begin
            o.element_count = cnt8;
        end
        if (k == drt_pkg::KIND_BOOL) begin
            o.bool_value = first && tru;
        end
        if (k == drt_pkg::KIND_INT) begin
            o.int_value = neg ? (32'd0 - acc)
                              : ((acc > drt_pkg::INT_POS_MAX) ? drt_pkg::INT_POS_MAX : acc);
        end
        return o;
    endfunction

    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign rec       = rec_reg;

    assign b   = cmd.sel_held ? byte_reg : s_data_byte;
    assign lst = cmd.sel_held ? last_reg : s_last_of_line;

    assign lim = ({1'b0, count_reg} < (drt_pkg::FIELD_W + 1)'(MAX_FIELDS))
               ? {1'b0, count_reg} : (drt_pkg::FIELD_W + 1)'(MAX_FIELDS);
    assign in_range = {1'b0, cur_reg} < lim;
    assign kind = (cur_reg >= drt_pkg::FIELD_W'(drt_pkg::KIND_FIELDS))
                ? drt_pkg::KIND_STRING
                : drt_pkg::kind_t'(kinds_reg[{cur_reg, 1'b0} +: 2]);
    assign is_start = (mode_reg == drt_pkg::MODE_START);

    // A field start sees the cleared per-field state.
    assign e_cnt   = is_start ? '0 : cnt_reg;
    assign e_first = is_start ? 1'b0 : first_reg;
    assign e_true  = is_start ? 1'b0 : true_reg;
    assign e_acc   = is_start ? 32'd0 : acc_reg;
    assign e_neg   = is_start ? 1'b0 : neg_reg;
    assign e_phase = is_start ? drt_pkg::PH_SKIP : phase_reg;

    assign is_blank = (b == drt_pkg::CH_SPACE) || ((b >= drt_pkg::CH_TAB) && (b <= drt_pkg::CH_CR));
    assign is_digit = (b >= drt_pkg::CH_ZERO) && (b <= drt_pkg::CH_NINE);

    // accumulate decimal digit: acc * 10 + d, saturating at the negative magnitude
    assign acc_prod = ({4'd0, e_acc} << 3) + ({4'd0, e_acc} << 1) + {32'd0, b[3:0]};
    assign acc_step = (acc_prod > {4'd0, drt_pkg::INT_MAG_MAX}) ? drt_pkg::INT_MAG_MAX
                                                                : acc_prod[31:0];

    // One parse step on the current byte.
    always_comb begin
        it_rec             = '0;
        it_rec.field_index = cur_reg;
        it_rec.char_out    = b;
        cur_next   = cur_reg;
        mode_next  = mode_reg;
        cnt_next   = e_cnt;
        first_next = e_first;
        true_next  = e_true;
        acc_next   = e_acc;
        neg_next   = e_neg;
        phase_next = e_phase;
        cont       = 1'b0;

        if (!in_range) begin
            // ignored byte; a line end still restarts the record
            if (lst) begin
                cur_next  = '0;
                mode_next = drt_pkg::MODE_START;
            end
        end else if (is_start && (kind == drt_pkg::KIND_LIST)) begin
            if (b == drt_pkg::CH_LBRK) begin
                mode_next = drt_pkg::MODE_LOPEN;
            end else begin
                // missing list: close empty, hand the byte on to the next field
                it_rec = fill_end(it_rec, kind, 8'd0, e_first, e_true, e_acc, e_neg);
                cur_next  = cur_reg + 5'd1;
                mode_next = drt_pkg::MODE_START;
                cont      = 1'b1;
            end
        end else if (is_start || (mode_reg == drt_pkg::MODE_TEXT)) begin
            if (b == drt_pkg::CH_SEMI) begin
                it_rec = fill_end(it_rec, kind, clamp8(e_cnt), e_first, e_true, e_acc, e_neg);
                cur_next  = cur_reg + 5'd1;
                mode_next = drt_pkg::MODE_START;
            end else begin
                it_rec.is_content = 1'b1;
                mode_next         = drt_pkg::MODE_TEXT;
                if (!e_first) begin
                    first_next = 1'b1;
                    true_next  = (b == drt_pkg::CH_TRUE);
                end
                unique case (e_phase)
                    drt_pkg::PH_SKIP: begin
                        priority if (is_blank) begin
                            phase_next = drt_pkg::PH_SKIP;
                        end else if ((b == drt_pkg::CH_PLUS) || (b == drt_pkg::CH_MINUS)) begin
                            neg_next   = (b == drt_pkg::CH_MINUS);
                            phase_next = drt_pkg::PH_DIGITS;
                        end else if (is_digit) begin
                            acc_next   = acc_step;
                            phase_next = drt_pkg::PH_DIGITS;
                        end else begin
                            phase_next = drt_pkg::PH_DONE;
                        end
                    end
                    drt_pkg::PH_DIGITS: begin
                        if (is_digit) begin
                            acc_next = acc_step;
                        end else begin
                            phase_next = drt_pkg::PH_DONE;
                        end
                    end
                    default: begin
                        phase_next = e_phase;
                    end
                endcase
            end
        end else begin
            it_rec.element_index = clamp8(cnt_reg);
            unique case (mode_reg)
                drt_pkg::MODE_LOPEN, drt_pkg::MODE_LELEM: begin
                    priority if (b == drt_pkg::CH_RBRK) begin
                        if (mode_reg == drt_pkg::MODE_LELEM) begin
                            it_rec.element_end = 1'b1;
                            cnt_next           = bump(cnt_reg);
                        end
                        mode_next = drt_pkg::MODE_LSKIP;
                    end else if (b == drt_pkg::CH_COMMA) begin
                        it_rec.element_end = 1'b1;
                        cnt_next           = bump(cnt_reg);
                        mode_next          = drt_pkg::MODE_LOPEN;
                    end else begin
                        it_rec.is_content = (b != drt_pkg::CH_QUOTE);
                        mode_next         = drt_pkg::MODE_LELEM;
                    end
                end
                drt_pkg::MODE_LSKIP: begin
                    // drop the byte after ']' and close the field on it
                    it_rec = fill_end(it_rec, kind, clamp8(cnt_reg), first_reg, true_reg,
                                      acc_reg, neg_reg);
                    cur_next  = cur_reg + 5'd1;
                    mode_next = drt_pkg::MODE_START;
                end
                default: begin
                    mode_next = drt_pkg::MODE_START;
                end
            endcase
        end
    end

    // Line-end close on the stepped record, from the state the step left.
    always_comb begin
        fin_rec           = rec_reg;
        fin_rec.line_done = 1'b1;
        fin_cnt           = (mode_reg == drt_pkg::MODE_LELEM) ? bump(cnt_reg) : cnt_reg;
        if ((mode_reg != drt_pkg::MODE_START) && in_range) begin
            if (mode_reg == drt_pkg::MODE_LELEM) begin
                fin_rec.element_end = 1'b1;
            end
            fin_rec = fill_end(fin_rec, kind, clamp8(fin_cnt), first_reg, true_reg,
                               acc_reg, neg_reg);
        end
    end

    always_comb begin
        sts.out_valid = out_valid_reg;
        sts.in_range  = in_range;
        sts.more      = cont && ({1'b0, cur_next} < lim);
        sts.last      = lst;
        sts.emit      = in_range || lst;
    end

    always_comb begin
        rec_next = rec_reg;
        if (cmd.step) begin
            rec_next = it_rec;
            if (!in_range) begin
                rec_next.line_done = lst;
            end
        end else if (cmd.finish) begin
            rec_next = fin_rec;
        end
    end

    always_comb begin
        if ((cmd.step && cmd.publish) || cmd.finish) begin
            out_valid_next = 1'b1;
        end else begin
            out_valid_next = out_valid_reg && !m_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= drt_pkg::FIELD_COUNT_RST;
            kinds_reg     <= drt_pkg::FIELD_KINDS_RST;
            cur_reg       <= '0;
            mode_reg      <= drt_pkg::MODE_START;
            cnt_reg       <= '0;
            first_reg     <= 1'b0;
            true_reg      <= 1'b0;
            acc_reg       <= 32'd0;
            neg_reg       <= 1'b0;
            phase_reg     <= drt_pkg::PH_SKIP;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    drt_pkg::REG_FIELD_COUNT: count_reg <= cfg_data[drt_pkg::FIELD_W-1:0];
                    drt_pkg::REG_FIELD_KINDS: kinds_reg <= cfg_data;
                    default: count_reg <= count_reg;
                endcase
            end
            if (cmd.finish) begin
                cur_reg   <= '0;
                mode_reg  <= drt_pkg::MODE_START;
                cnt_reg   <= '0;
                first_reg <= 1'b0;
                true_reg  <= 1'b0;
                acc_reg   <= 32'd0;
                neg_reg   <= 1'b0;
                phase_reg <= drt_pkg::PH_SKIP;
            end else if (cmd.step) begin
                cur_reg   <= cur_next;
                mode_reg  <= mode_next;
                cnt_reg   <= cnt_next;
                first_reg <= first_next;
                true_reg  <= true_next;
                acc_reg   <= acc_next;
                neg_reg   <= neg_next;
                phase_reg <= phase_next;
            end
        end
    end

    // Payload: held byte and result record.
    always_ff @(posedge aclk) begin
        if (cmd.step && !cmd.sel_held) begin
            byte_reg <= s_data_byte;
            last_reg <= s_last_of_line;
        end
        rec_reg <= rec_next;
    end

endmodule

// ===== design/delimited_record_tokenizer.sv =====
// Top level of the delimited record tokenizer: controller plus datapath.
// Depends on drt_pkg, drt_ctrl and drt_datapath.
//
// Takes one byte per item and gives one result item per handled byte position of a
// ';'-separated record line. A list field that does not open with '[' closes empty and
// the same byte is handled again for the next field. When the line's last byte lands on
// a field below the field limit, a separate finish step closes the line, and any field
// still open, before the next item is accepted. Results leave through one output
// register, so a new byte is taken in the cycle the previous result is taken.
// Configuration (index 0 field_count, index 1 field_kinds) is to be written by the user
// between lines only; the block does not enforce this. It is always ready.
module delimited_record_tokenizer #(
    parameter int MAX_FIELDS   = 24,
    parameter int MAX_ELEMENTS = 255
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [7:0]                          s_data_byte,
    input  logic                                s_last_of_line,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [drt_pkg::FIELD_W-1:0]         m_field_index,
    output logic [7:0]                          m_element_index,
    output logic [7:0]                          m_char_out,
    output logic                                m_is_content,
    output logic                                m_element_end,
    output logic                                m_field_end,
    output logic [7:0]                          m_element_count,
    output logic                                m_bool_value,
    output logic signed [31:0]                  m_int_value,
    output logic                                m_line_done,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [drt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [drt_pkg::KINDS_W-1:0]         cfg_data
);

    drt_pkg::drt_cmd_t cmd;
    drt_pkg::drt_sts_t sts;
    drt_pkg::drt_rec_t rec;

    drt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .s_ready (s_ready),
        .cmd     (cmd)
    );

    drt_datapath #(
        .MAX_FIELDS   (MAX_FIELDS),
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_data_byte    (s_data_byte),
        .s_last_of_line (s_last_of_line),
        .m_ready        (m_ready),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cmd            (cmd),
        .sts            (sts),
        .m_valid        (m_valid),
        .rec            (rec)
    );

    assign m_field_index   = rec.field_index;
    assign m_element_index = rec.element_index;
    assign m_char_out      = rec.char_out;
    assign m_is_content    = rec.is_content;
    assign m_element_end   = rec.element_end;
    assign m_field_end     = rec.field_end;
    assign m_element_count = rec.element_count;
    assign m_bool_value    = rec.bool_value;
    assign m_int_value     = rec.int_value;
    assign m_line_done     = rec.line_done;

endmodule

// ===== design/drt_checker.sv =====
// Port-level checks on the tokenizer's result channel, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module drt_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [4:0]         m_field_index,
    input logic [7:0]         m_element_index,
    input logic [7:0]         m_char_out,
    input logic               m_is_content,
    input logic               m_element_end,
    input logic               m_field_end,
    input logic [7:0]         m_element_count,
    input logic               m_bool_value,
    input logic signed [31:0] m_int_value,
    input logic               m_line_done
);

    `DRT_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_char_out) && $stable(m_field_index) && $stable(m_field_end), "result changed while stalled")

    `DRT_ASSERT_IMP(a_end_data_only, aclk, aresetn, m_valid && !m_field_end, (m_element_count == 8'd0) && !m_bool_value && (m_int_value == 32'sd0), "field data without a field end")

    `DRT_ASSERT_IMP(a_content_open, aclk, aresetn, m_valid && m_is_content && !m_line_done, !m_element_end && !m_field_end, "content byte closes a field before line end")

    `DRT_ASSERT_IMP(a_tail_string, aclk, aresetn, m_valid && (m_field_index > 5'd23), (m_element_count == 8'd0) && !m_bool_value && (m_int_value == 32'sd0) && !m_element_end && (m_element_index == 8'd0), "field above the kind table not treated as string")

endmodule

bind delimited_record_tokenizer drt_checker u_drt_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_field_index   (m_field_index),
    .m_element_index (m_element_index),
    .m_char_out      (m_char_out),
    .m_is_content    (m_is_content),
    .m_element_end   (m_element_end),
    .m_field_end     (m_field_end),
    .m_element_count (m_element_count),
    .m_bool_value    (m_bool_value),
    .m_int_value     (m_int_value),
    .m_line_done     (m_line_done)
);

// ===== dv/drt_check_pkg.sv =====
// Scoreboard for the delimited record tokenizer testbench: a line-parsing predictor
// plus the queue of result items it expects. Depends on drt_pkg.
package drt_check_pkg;
    import drt_pkg::*;

    localparam int ELEM_SAT   = 255;
    localparam int REPORT_MAX = 10;

    class drt_scoreboard;
        drt_rec_t           result_q[$];
        logic [FIELD_W-1:0] field_count;
        logic [KINDS_W-1:0] field_kinds;
        int                 cur_field;
        mode_t              mode;
        int                 elem_cnt;
        bit                 seen;
        bit                 true_seen;
        logic [31:0]        magnitude;
        bit                 negative;
        phase_t             phase;
        int                 errors;

        function new();
            field_count = FIELD_COUNT_RST;
            field_kinds = FIELD_KINDS_RST;
            errors = 0;
            restart_line();
        endfunction

        function void open_field();
            elem_cnt = 0;
            seen = 1'b0;
            true_seen = 1'b0;
            magnitude = '0;
            negative = 1'b0;
            phase = PH_SKIP;
        endfunction

        function void restart_line();
            cur_field = 0;
            mode = MODE_START;
            open_field();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [KINDS_W-1:0] data);
            if (idx == REG_FIELD_COUNT) begin
                field_count = data[FIELD_W-1:0];
            end else begin
                field_kinds = data;
            end
        endfunction

        function kind_t kind_of(int f);
            if (f >= KIND_FIELDS) return KIND_STRING;
            return kind_t'(field_kinds[2*f +: 2]);
        endfunction

        function int field_limit();
            return (field_count < KIND_FIELDS) ? int'(field_count) : KIND_FIELDS;
        endfunction

        function void count_element();
            if (elem_cnt < ELEM_SAT) elem_cnt++;
        endfunction

        function drt_rec_t close_field(drt_rec_t r);
            drt_rec_t c;
            c = r;
            c.field_end = 1'b1;
            case (kind_of(cur_field))
                KIND_LIST: c.element_count = 8'(elem_cnt);
                KIND_BOOL: c.bool_value = seen && true_seen;
                KIND_INT: begin
                    if (negative) c.int_value = 32'd0 - magnitude;
                    else c.int_value = (magnitude > INT_POS_MAX) ? INT_POS_MAX : magnitude;
                end
                default: ;
            endcase
            return c;
        endfunction

        // atoi-style scan: blanks, one sign, digits; the magnitude saturates at 2^31
        function void take_text(logic [7:0] b);
            bit          blank;
            bit          digit;
            logic [63:0] t;
            blank = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
            digit = (b >= CH_ZERO) && (b <= CH_NINE);
            if (!seen) begin
                seen = 1'b1;
                true_seen = (b == CH_TRUE);
            end
            if (phase == PH_SKIP) begin
                if (blank) return;
                if (b == CH_PLUS || b == CH_MINUS) begin
                    negative = (b == CH_MINUS);
                    phase = PH_DIGITS;
                    return;
                end
                phase = digit ? PH_DIGITS : PH_DONE;
            end
            if (phase == PH_DIGITS) begin
                if (digit) begin
                    t = 64'(magnitude) * 64'd10 + 64'(b - CH_ZERO);
                    magnitude = (t > 64'(INT_MAG_MAX)) ? INT_MAG_MAX : t[31:0];
                end else begin
                    phase = PH_DONE;
                end
            end
        endfunction

        function void note_input(logic [7:0] b, bit eol);
            drt_rec_t step_q[$];
            drt_rec_t r;
            kind_t    k;
            bit       done;
            done = 1'b0;
            while (!done) begin
                if (cur_field >= field_limit()) begin
                    // past the last field: only a line end gives a result
                    if (step_q.size() == 0 && eol) begin
                        r = '0;
                        r.field_index = FIELD_W'(cur_field);
                        r.char_out = b;
                        step_q.push_back(r);
                    end
                    done = 1'b1;
                end else if (step_q.size() >= KIND_FIELDS) begin
                    done = 1'b1;
                end else begin
                    k = kind_of(cur_field);
                    r = '0;
                    r.field_index = FIELD_W'(cur_field);
                    r.char_out = b;
                    if (mode == MODE_START && k == KIND_LIST) begin
                        open_field();
                        if (b == CH_LBRK) begin
                            mode = MODE_LOPEN;
                            done = 1'b1;
                        end else begin
                            // no opening bracket: close empty, hand the byte to the next field
                            r = close_field(r);
                            cur_field++;
                        end
                    end else begin
                        if (mode == MODE_START) begin
                            open_field();
                            mode = MODE_TEXT;
                        end
                        case (mode)
                            MODE_TEXT: begin
                                if (b == CH_SEMI) begin
                                    r = close_field(r);
                                    cur_field++;
                                    mode = MODE_START;
                                end else begin
                                    r.is_content = 1'b1;
                                    take_text(b);
                                end
                            end
                            MODE_LOPEN, MODE_LELEM: begin
                                r.element_index = 8'(elem_cnt);
                                if (b == CH_RBRK) begin
                                    if (mode == MODE_LELEM) begin
                                        r.element_end = 1'b1;
                                        count_element();
                                    end
                                    mode = MODE_LSKIP;
                                end else if (b == CH_COMMA) begin
                                    r.element_end = 1'b1;
                                    count_element();
                                    mode = MODE_LOPEN;
                                end else begin
                                    r.is_content = (b != CH_QUOTE);
                                    mode = MODE_LELEM;
                                end
                            end
                            default: begin
                                // drop the byte after ']' and close the list
                                r.element_index = 8'(elem_cnt);
                                r = close_field(r);
                                cur_field++;
                                mode = MODE_START;
                            end
                        endcase
                        done = 1'b1;
                    end
                    step_q.push_back(r);
                end
            end
            if (eol && step_q.size() > 0) begin
                r = step_q[step_q.size()-1];
                r.line_done = 1'b1;
                if (mode != MODE_START && cur_field < field_limit()) begin
                    if (mode == MODE_LELEM) begin
                        r.element_end = 1'b1;
                        count_element();
                    end
                    r = close_field(r);
                end
                step_q[step_q.size()-1] = r;
            end
            if (eol) restart_line();
            foreach (step_q[i]) result_q.push_back(step_q[i]);
        endfunction

        function string describe(drt_rec_t r);
            return $sformatf({"field %0d elem %0d char %02h content %0b elem_end %0b ",
                              "field_end %0b count %0d bool %0b int %0d done %0b"},
                             r.field_index, r.element_index, r.char_out, r.is_content,
                             r.element_end, r.field_end, r.element_count, r.bool_value,
                             r.int_value, r.line_done);
        endfunction

        function void check_result(drt_rec_t got);
            drt_rec_t want;
            if (result_q.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected result item: %s", describe(got));
            end else begin
                want = result_q.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= REPORT_MAX)
                        $display("result mismatch\n  expected %s\n  actual   %s",
                                 describe(want), describe(got));
                end
            end
        endfunction

        function int pending();
            return result_q.size();
        endfunction
    endclass

endpackage

// ===== dv/tb_delimited_record_tokenizer.sv =====
// Top-level testbench of the delimited record tokenizer: clock, reset, byte, result
// and configuration drivers, record-line generator. Depends on drt_pkg and drt_check_pkg.
module tb_delimited_record_tokenizer;
    import drt_pkg::*;
    import drt_check_pkg::*;

    typedef logic [7:0] octet_t;

    localparam int LINE_MAX = 20;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [7:0]           s_data_byte;
    logic                 s_last_of_line;
    logic                 m_valid;
    logic                 m_ready;
    logic [FIELD_W-1:0]   m_field_index;
    logic [7:0]           m_element_index;
    logic [7:0]           m_char_out;
    logic                 m_is_content;
    logic                 m_element_end;
    logic                 m_field_end;
    logic [7:0]           m_element_count;
    logic                 m_bool_value;
    logic signed [31:0]   m_int_value;
    logic                 m_line_done;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [KINDS_W-1:0]   cfg_data;

    drt_scoreboard      sb = new();
    octet_t             line_q[$];
    logic [FIELD_W-1:0] cfg_count = FIELD_COUNT_RST;
    logic [KINDS_W-1:0] cfg_kinds = FIELD_KINDS_RST;
    bit                 steady = 1'b0;
    int                 items_sent = 0;

    delimited_record_tokenizer dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_last_of_line  (s_last_of_line),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_field_index   (m_field_index),
        .m_element_index (m_element_index),
        .m_char_out      (m_char_out),
        .m_is_content    (m_is_content),
        .m_element_end   (m_element_end),
        .m_field_end     (m_field_end),
        .m_element_count (m_element_count),
        .m_bool_value    (m_bool_value),
        .m_int_value     (m_int_value),
        .m_line_done     (m_line_done),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("tb_delimited_record_tokenizer: FAIL");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_byte(input octet_t b, input bit eol);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_data_byte    <= b;
        s_last_of_line <= eol;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(b, eol);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_line();
        int i;
        for (i = 0; i < line_q.size(); i++) send_byte(line_q[i], i == line_q.size() - 1);
        line_q.delete();
    endtask

    // Hold the sender until every expected item is out, then let the block settle.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [KINDS_W-1:0] d);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, d);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [FIELD_W-1:0] count, input logic [KINDS_W-1:0] kinds);
        wait_idle();
        // upper bits are junk on purpose: only the low five bits count
        cfg_write(REG_FIELD_COUNT, {16'($urandom), 27'($urandom), count});
        cfg_write(REG_FIELD_KINDS, kinds);
        cfg_count = count;
        cfg_kinds = kinds;
    endtask

    task automatic push_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++) line_q.push_back(s[i]);
    endtask

    function automatic octet_t text_char();
        octet_t c;
        c = 8'($urandom_range(32, 126));
        return (c == CH_SEMI) ? CH_SPACE : c;
    endfunction

    function automatic octet_t elem_char();
        octet_t c;
        c = text_char();
        return (c == CH_COMMA || c == CH_RBRK) ? CH_QUOTE : c;
    endfunction

    // Mostly well-formed records for the current kinds; some noise and cut-off lines.
    task automatic build_record();
        int    lim, f, n, i, r;
        kind_t k;
        lim = (cfg_count > KIND_FIELDS) ? KIND_FIELDS : int'(cfg_count);
        if ($urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 8);
            repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        for (f = 0; f < lim; f++) begin
            k = kind_t'(cfg_kinds[2*f +: 2]);
            case (k)
                KIND_LIST: begin
                    // skip the field now and then: a list without '[' closes empty
                    if ($urandom_range(0, 5) != 0) begin
                        line_q.push_back(CH_LBRK);
                        n = $urandom_range(0, 3);
                        for (i = 0; i < n; i++) begin
                            if (i > 0) line_q.push_back(CH_COMMA);
                            repeat ($urandom_range(0, 3)) line_q.push_back(elem_char());
                        end
                        line_q.push_back(CH_RBRK);
                        line_q.push_back(($urandom_range(0, 3) != 0) ? CH_SEMI : text_char());
                    end
                end
                KIND_BOOL: begin
                    line_q.push_back($urandom_range(0, 1) ? CH_TRUE : text_char());
                    repeat ($urandom_range(0, 2)) line_q.push_back(text_char());
                end
                KIND_INT: begin
                    repeat ($urandom_range(0, 2)) begin
                        r = $urandom_range(0, 5);
                        line_q.push_back((r == 0) ? CH_SPACE : 8'(CH_TAB + r - 1));
                    end
                    r = $urandom_range(0, 2);
                    if (r == 1) line_q.push_back(CH_PLUS);
                    if (r == 2) line_q.push_back(CH_MINUS);
                    n = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 12) : $urandom_range(0, 4);
                    repeat (n) line_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                    if ($urandom_range(0, 3) == 0) line_q.push_back(text_char());
                end
                default: repeat ($urandom_range(0, 4)) line_q.push_back(text_char());
            endcase
            if (k != KIND_LIST && (f < lim - 1 || $urandom_range(0, 1) == 1))
                line_q.push_back(CH_SEMI);
        end
        if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) line_q.push_back(text_char());
        if (line_q.size() > 1 && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, line_q.size() - 1);
            while (line_q.size() > n) void'(line_q.pop_back());
        end
        // keep lines short so the run stays near its item budget
        while (line_q.size() > LINE_MAX) void'(line_q.pop_back());
        if (line_q.size() == 0) line_q.push_back(text_char());
    endtask

    // result side: random stalls, check every accepted item
    initial begin
        drt_rec_t got;
        int       gap;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            gap = steady ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got.field_index   = m_field_index;
            got.element_index = m_element_index;
            got.char_out      = m_char_out;
            got.is_content    = m_is_content;
            got.element_end   = m_element_end;
            got.field_end     = m_field_end;
            got.element_count = m_element_count;
            got.bool_value    = m_bool_value;
            got.int_value     = m_int_value;
            got.line_done     = m_line_done;
            sb.check_result(got);
            @(negedge aclk);
        end
    end

    initial begin
        int p, lines, phase_start, rand_start;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data_byte    = '0;
        s_last_of_line = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: reset registers, chained empty lists up to the field limit,
        // saturating integer, empty element, line end inside an open element,
        // skipped byte, ignored byte
        push_str("V;x;[a]");
        send_line();
        set_config(5'd31, 48'h5555_5555_5555);
        line_q.push_back(8'hFF);
        send_line();
        set_config(5'd2, 48'h7);
        push_str("-9999999999;[,'");
        send_line();
        line_q.push_back(8'h00);
        push_str(";[]zq");
        send_line();

        rand_start = items_sent;
        for (p = 0; p < 6 || items_sent - rand_start < 120; p++) begin
            case (p % 6)
                0: set_config(5'($urandom_range(1, 5)), {16'($urandom), 32'($urandom)});
                1: set_config(5'd24, '0);
                2: set_config(5'd31, {16'($urandom), 32'($urandom)});
                3: set_config(5'd0, '1);
                4: set_config(5'($urandom_range(1, 8)), 48'h5555_5555_5555);
                default: set_config(5'd2, 48'hD);
            endcase
            steady = (p % 6 == 4);
            lines = 0;
            phase_start = items_sent;
            while (items_sent - phase_start < 14) begin
                if (p % 6 == 2 && lines == 1) wait_idle();
                build_record();
                send_line();
                lines++;
            end
        end
        steady = 1'b0;

        wait_idle();
        repeat (12) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_delimited_record_tokenizer: PASS");
        end else begin
            $display("tb_delimited_record_tokenizer: FAIL");
        end
        $finish;
    end

endmodule
